/* design/ts_sr_pkg.sv */
package ts_sr_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [12:0] pid_t;

	// transport stream packet layout
	localparam byte_t PKT_LEN    = 8'd188;
	localparam byte_t SYNC_BYTE  = 8'h47;
	localparam byte_t HDR_LEN    = 8'd4;

	// header bit positions
	localparam int UNIT_START_BIT = 6;   // byte 1
	localparam int ADAPT_BIT      = 5;   // byte 3
	localparam int PAYLOAD_BIT    = 4;   // byte 3

endpackage

/* design/ts_sr_if.sv */
// Byte stream channel into the reassembler
interface ts_in_if;
	import ts_sr_pkg::*;

	logic  valid;
	logic  ready;
	byte_t ts_byte;
	logic  packet_first;

	modport source (output valid, output ts_byte, output packet_first, input ready);
	modport sink   (input valid, input ts_byte, input packet_first, output ready);
endinterface

// Section byte channel out of the reassembler
interface sec_out_if;
	import ts_sr_pkg::*;

	logic  valid;
	logic  ready;
	byte_t section_byte;
	logic  section_last;

	modport source (output valid, output section_byte, output section_last, input ready);
	modport sink   (input valid, input section_byte, input section_last, output ready);
endinterface

/* design/ts_section_reassembler.sv */
// Transport stream section reassembler.
// Channel ts: one stream byte per item, packet_first marks byte 0 of each
// 188-byte packet. Channel sec: one section byte per item, section_last on
// the final byte. cfg_we/cfg_wdata load the 13-bit PID filter (reset 0);
// write it only while the block is idle.
// Packets are kept when sync is 0x47, the PID matches, the continuity counter
// follows and the payload flag is set. Adaptation field and pointer byte are
// skipped; a section starts on a unit-start packet and runs for its length
// field plus 3 bytes, after which the rest of that packet is discarded.
// Throughput: one input item per clock while ts.ready is high. Each item is decoded in
// the cycle it is accepted and its result, if any, is registered in the output
// register, so it shows on sec.valid in the cycle after acceptance.
// When the receiver stalls, the output register holds its item and ts.ready
// drops only while that register is full and not being taken; a waiting
// result never blocks an item in the same cycle it is taken.
// Asynchronous reset initialises all filter state and clears the output valid flag.
module ts_section_reassembler (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  ts_sr_pkg::pid_t  cfg_wdata,
	ts_in_if.sink            ts,
	sec_out_if.source        sec
);
	import ts_sr_pkg::*;

	typedef enum logic [1:0] {
		HS_IDLE   = 2'd0,
		HS_FIRST  = 2'd1,
		HS_SECOND = 2'd2,
		HS_BODY   = 2'd3
	} hdr_step_t;

	// state registers
	pid_t       pid_filter_q;
	byte_t      byte_index_q,    byte_index_n;
	logic       packet_keep_q,   packet_keep_n;
	logic [4:0] pid_high_q,      pid_high_n;
	logic       unit_start_q,    unit_start_n;
	logic [1:0] header_flags_q,  header_flags_n;
	byte_t      payload_begin_q, payload_begin_n;
	logic [3:0] last_cc_q,       last_cc_n;
	logic       cc_valid_q,      cc_valid_n;
	logic       sec_active_q,    sec_active_n;
	hdr_step_t  header_step_q,   header_step_n;
	logic [3:0] length_high_q,   length_high_n;
	logic [11:0] remaining_q,    remaining_n;
	logic       rest_dropped_q,  rest_dropped_n;

	// output register
	logic  out_valid_q;
	byte_t out_byte_q;
	logic  out_last_q;

	logic       acc;
	logic       emit_n;
	logic       last_n;
	byte_t      b;
	byte_t      pos;
	logic [3:0] cc;
	logic [8:0] begin_w;
	logic [11:0] len_w;
	logic [11:0] rem_dec;

	assign ts.ready         = !out_valid_q || sec.ready;
	assign acc              = ts.valid && ts.ready;
	assign sec.valid        = out_valid_q;
	assign sec.section_byte = out_byte_q;
	assign sec.section_last = out_last_q;

	assign b       = ts.ts_byte;
	assign cc      = b[3:0];
	assign begin_w = {1'b0, b} + 9'd5 + {8'd0, unit_start_q};
	assign len_w   = {length_high_q, b};
	assign rem_dec = (remaining_q != 12'd0) ? remaining_q - 12'd1 : remaining_q;

	// position within the packet, saturating past the end
	always_comb begin
		if (ts.packet_first)
			pos = 8'd0;
		else if (byte_index_q >= PKT_LEN)
			pos = PKT_LEN;
		else
			pos = byte_index_q + 8'd1;
	end

	// per-byte decode
	always_comb begin
		byte_index_n    = pos;
		packet_keep_n   = packet_keep_q;
		pid_high_n      = pid_high_q;
		unit_start_n    = unit_start_q;
		header_flags_n  = header_flags_q;
		payload_begin_n = payload_begin_q;
		last_cc_n       = last_cc_q;
		cc_valid_n      = cc_valid_q;
		sec_active_n    = sec_active_q;
		header_step_n   = header_step_q;
		length_high_n   = length_high_q;
		remaining_n     = remaining_q;
		rest_dropped_n  = rest_dropped_q;
		emit_n          = 1'b0;
		last_n          = 1'b0;

		if (pos == 8'd0) begin
			packet_keep_n   = (b == SYNC_BYTE);
			rest_dropped_n  = 1'b0;
			unit_start_n    = 1'b0;
			header_flags_n  = 2'b00;
			payload_begin_n = PKT_LEN;
		end else if (packet_keep_q && pos < PKT_LEN) begin
			if (pos == 8'd1) begin
				pid_high_n   = b[4:0];
				unit_start_n = b[UNIT_START_BIT];
			end else if (pos == 8'd2) begin
				if ({pid_high_q, b} != pid_filter_q)
					packet_keep_n = 1'b0;
			end else if (pos == 8'd3) begin
				if (cc_valid_q && cc != last_cc_q + 4'd1) begin
					packet_keep_n = 1'b0;
				end else begin
					last_cc_n      = cc;
					cc_valid_n     = 1'b1;
					header_flags_n = {b[PAYLOAD_BIT], b[ADAPT_BIT]};
					if (!b[PAYLOAD_BIT])
						packet_keep_n = 1'b0;
					else if (b[ADAPT_BIT])
						payload_begin_n = PKT_LEN;
					else
						payload_begin_n = HDR_LEN + {7'd0, unit_start_q};
				end
			end else if (pos == 8'd4 && header_flags_q[0]) begin
				// adaptation field length, clipped to packet end
				payload_begin_n = (begin_w > {1'b0, PKT_LEN}) ? PKT_LEN : begin_w[7:0];
			end else if (pos >= payload_begin_q && !rest_dropped_q) begin
				// section bytes
				if (!sec_active_q) begin
					if (unit_start_q) begin
						sec_active_n  = 1'b1;
						header_step_n = HS_FIRST;
						emit_n        = 1'b1;
					end
				end else begin
					emit_n = 1'b1;
					case (header_step_q)
						HS_FIRST: begin
							length_high_n = b[3:0];
							header_step_n = HS_SECOND;
						end
						HS_SECOND: begin
							remaining_n   = len_w;
							header_step_n = HS_BODY;
							last_n        = (len_w == 12'd0);
						end
						default: begin
							remaining_n = rem_dec;
							last_n      = (rem_dec == 12'd0);
						end
					endcase
				end
				if (last_n) begin
					sec_active_n   = 1'b0;
					header_step_n  = HS_IDLE;
					remaining_n    = 12'd0;
					rest_dropped_n = 1'b1;
				end
			end
		end
	end

	// state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid_filter_q    <= '0;
			byte_index_q    <= '0;
			packet_keep_q   <= 1'b0;
			pid_high_q      <= '0;
			unit_start_q    <= 1'b0;
			header_flags_q  <= '0;
			payload_begin_q <= HDR_LEN;
			last_cc_q       <= '0;
			cc_valid_q      <= 1'b0;
			sec_active_q    <= 1'b0;
			header_step_q   <= HS_IDLE;
			length_high_q   <= '0;
			remaining_q     <= '0;
			rest_dropped_q  <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we)
				pid_filter_q <= cfg_wdata;
			if (acc) begin
				byte_index_q    <= byte_index_n;
				packet_keep_q   <= packet_keep_n;
				pid_high_q      <= pid_high_n;
				unit_start_q    <= unit_start_n;
				header_flags_q  <= header_flags_n;
				payload_begin_q <= payload_begin_n;
				last_cc_q       <= last_cc_n;
				cc_valid_q      <= cc_valid_n;
				sec_active_q    <= sec_active_n;
				header_step_q   <= header_step_n;
				length_high_q   <= length_high_n;
				remaining_q     <= remaining_n;
				rest_dropped_q  <= rest_dropped_n;
				out_valid_q     <= emit_n;
			end else if (sec.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (acc && emit_n) begin
			out_byte_q <= b;
			out_last_q <= last_n;
		end
	end

`ifndef ASSERT_OFF
	// packet position never runs past the saturation point
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q <= PKT_LEN)
		else $error("byte index beyond packet length");

	// header step tracks whether a section is open
	a_step_active: assert property (@(posedge clk) disable iff (!arst_n)
		sec_active_q == (header_step_q != HS_IDLE))
		else $error("header step out of step with section state");

	// a final byte closes the section and drops the rest of the packet
	a_last_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && emit_n && last_n) |=> (rest_dropped_q && !sec_active_q && out_last_q))
		else $error("section end not followed by drop");
`endif

endmodule

/* tb/sv/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ts_sr_pkg::*;

	localparam int   CYCLE_LIMIT   = 200000;
	localparam int   SETTLE_CYCLES = 8;
	localparam int   IDLE_PCT      = 20;
	localparam int   RANDOM_BYTES  = 160;
	localparam int   REPORT_MAX    = 40;
	localparam int   LONG_STALL    = 400;
	localparam pid_t PID_MAX       = 13'h1fff;

	// ways of spoiling a packet
	typedef enum int {
		NOISE_WRONG_PID,
		NOISE_BAD_SYNC,
		NOISE_BAD_CC,
		NOISE_NO_PAYLOAD,
		NOISE_ADAPT_FILL,
		NOISE_LONE_PAYLOAD,
		NOISE_RUNT
	} noise_kind_e;

	typedef struct {
		byte_t data;
		logic  last;
	} sec_byte_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	pid_t cfg_wdata;

	ts_in_if   ts_ch ();
	sec_out_if sec_ch ();

	ts_section_reassembler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ts        (ts_ch),
		.sec       (sec_ch)
	);

	// section bytes predicted but not yet seen, and bytes still to be packed
	sec_byte_t section_due[$];
	byte_t     sec_feed[$];

	int errors        = 0;
	int bytes_sent    = 0;
	int cycle_count   = 0;
	int in_idle_pct   = IDLE_PCT;
	int out_idle_pct  = IDLE_PCT;
	int stall_request = 0;

	// mirror of the filter state
	pid_t        m_pid;
	byte_t       m_index;
	logic        m_keep;
	logic [4:0]  m_pid_hi;
	logic        m_pusi;
	logic [1:0]  m_flags;     // bit0 adaptation field, bit1 payload
	byte_t       m_begin;
	logic [3:0]  m_cc;
	logic        m_cc_valid;
	logic        m_active;
	logic [1:0]  m_hstep;
	logic [3:0]  m_len_hi;
	logic [12:0] m_remaining;
	logic        m_dropped;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one section byte is due; the last one closes the section
	task automatic due_byte(input byte_t b, input logic last);
		sec_byte_t item;
		item.data = b;
		item.last = last;
		section_due.push_back(item);
		if (last) begin
			m_active    = 1'b0;
			m_hstep     = 2'd0;
			m_remaining = '0;
			m_dropped   = 1'b1;
		end
	endtask

	// advance the mirror by one accepted stream byte
	task automatic track_stream_byte(input byte_t b, input logic first);
		int pos;
		int start;
		if (first) begin
			pos = 0;
		end else begin
			pos = int'(m_index) + 1;
			if (pos > PKT_LEN)
				pos = int'(PKT_LEN);
		end
		m_index = pos[7:0];

		if (pos == 0) begin
			m_keep    = (b == SYNC_BYTE);
			m_dropped = 1'b0;
			m_pusi    = 1'b0;
			m_flags   = 2'd0;
			m_begin   = PKT_LEN;
			return;
		end
		if (!m_keep || pos >= PKT_LEN)
			return;

		// packet header
		if (pos == 1) begin
			m_pid_hi = b[4:0];
			m_pusi   = b[UNIT_START_BIT];
			return;
		end
		if (pos == 2) begin
			if ({m_pid_hi, b} != m_pid)
				m_keep = 1'b0;
			return;
		end
		if (pos == 3) begin
			if (m_cc_valid && b[3:0] != m_cc + 4'd1) begin
				m_keep = 1'b0;
				return;
			end
			m_cc       = b[3:0];
			m_cc_valid = 1'b1;
			m_flags    = {b[PAYLOAD_BIT], b[ADAPT_BIT]};
			if (!b[PAYLOAD_BIT]) begin
				m_keep = 1'b0;
				return;
			end
			m_begin = m_flags[0] ? PKT_LEN : HDR_LEN + m_pusi;
			return;
		end
		if (pos == 4 && m_flags[0]) begin
			start   = b + 5 + m_pusi;
			m_begin = (start > PKT_LEN) ? PKT_LEN : start[7:0];
			return;
		end
		if (pos < m_begin || m_dropped)
			return;

		// payload: section header, then body
		if (!m_active) begin
			if (!m_pusi)
				return;
			m_active = 1'b1;
			m_hstep  = 2'd1;
			due_byte(b, 1'b0);
		end else if (m_hstep == 2'd1) begin
			m_len_hi = b[3:0];
			m_hstep  = 2'd2;
			due_byte(b, 1'b0);
		end else if (m_hstep == 2'd2) begin
			m_remaining = {1'b0, m_len_hi, b};
			m_hstep     = 2'd3;
			due_byte(b, m_remaining == 0);
		end else begin
			if (m_remaining != 0)
				m_remaining--;
			due_byte(b, m_remaining == 0);
		end
	endtask

	// offer one stream byte and wait until it is taken
	task automatic send_byte(input byte_t b, input logic first);
		@(negedge clk);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			ts_ch.valid <= 1'b0;
			@(negedge clk);
		end
		ts_ch.valid        <= 1'b1;
		ts_ch.ts_byte      <= b;
		ts_ch.packet_first <= first;
		@(posedge clk);
		while (!ts_ch.ready)
			@(posedge clk);
		bytes_sent++;
		track_stream_byte(b, first);
	endtask

	task automatic release_input();
		@(negedge clk);
		ts_ch.valid <= 1'b0;
	endtask

	// PID filter write, only once the block has drained
	task automatic write_pid(input pid_t value);
		release_input();
		while (section_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		m_pid = value;
	endtask

	// build and send one packet; payload comes from sec_feed when feeding
	task automatic send_packet(input int len, input logic sync_ok, input pid_t pid,
			input logic pusi, input logic adapt, input logic has_pl,
			input logic [3:0] cc, input int alen, input logic feeding);
		int    pl_start;
		int    i;
		byte_t b;
		pl_start = adapt ? alen + 5 + pusi : 4 + pusi;
		for (i = 0; i < len; i++) begin
			b = byte_t'($urandom);
			if (i == 0) begin
				if (sync_ok)
					b = SYNC_BYTE;
				else if (b == SYNC_BYTE)
					b = ~b;
			end else if (i == 1) begin
				b[4:0]           = pid[12:8];
				b[UNIT_START_BIT] = pusi;
			end else if (i == 2) begin
				b = pid[7:0];
			end else if (i == 3) begin
				b[3:0]        = cc;
				b[ADAPT_BIT]   = adapt;
				b[PAYLOAD_BIT] = has_pl;
			end else if (i == 4 && adapt) begin
				b = alen[7:0];
			end else if (feeding && i >= pl_start && i < PKT_LEN && sec_feed.size() != 0) begin
				b = sec_feed.pop_front();
			end
			send_byte(b, i == 0);
		end
	endtask

	// well-formed packet on the filtered PID; opens a section when none is running
	task automatic send_good_packet(input int len, input int alen, input int sec_len);
		logic        pusi;
		int          pl_start;
		logic [11:0] field;
		byte_t       b;
		pusi     = !m_active;
		pl_start = (alen >= 0) ? alen + 5 + pusi : 4 + pusi;
		if (pusi) begin
			field = sec_len[11:0];
			sec_feed.delete();
			b = byte_t'($urandom);
			sec_feed.push_back(b);
			b = byte_t'($urandom);
			b[3:0] = field[11:8];
			sec_feed.push_back(b);
			sec_feed.push_back(field[7:0]);
			repeat (field) begin
				b = byte_t'($urandom);
				sec_feed.push_back(b);
			end
		end
		// at least one payload byte so the section really starts here
		if (len <= pl_start)
			len = pl_start + 1;
		send_packet(len, 1'b1, m_pid, pusi, alen >= 0, 1'b1, m_cc + 4'd1, alen, 1'b1);
	endtask

	task automatic send_noise_packet(input noise_kind_e kind, input int len);
		pid_t       pid;
		logic       sync_ok;
		logic       pusi;
		logic       adapt;
		logic       has_pl;
		logic [3:0] cc;
		int         alen;
		pid     = m_pid;
		sync_ok = 1'b1;
		pusi    = 1'($urandom_range(0, 1));
		adapt   = 1'($urandom_range(0, 1));
		has_pl  = 1'b1;
		cc      = m_cc + 4'd1;
		alen    = $urandom_range(0, 12);
		case (kind)
			NOISE_WRONG_PID: begin
				pid = m_pid ^ pid_t'($urandom_range(1, 8191));
				cc  = 4'($urandom_range(0, 15));
			end
			NOISE_BAD_SYNC:   sync_ok = 1'b0;
			NOISE_BAD_CC:     cc = m_cc + 4'($urandom_range(2, 16));
			NOISE_NO_PAYLOAD: has_pl = 1'b0;
			NOISE_ADAPT_FILL: begin
				adapt = 1'b1;
				alen  = $urandom_range(183, 255);
			end
			NOISE_LONE_PAYLOAD: begin
				pusi  = 1'b0;
				adapt = 1'b0;
			end
			default: ;
		endcase
		send_packet(len, sync_ok, pid, pusi, adapt, has_pl, cc, alen, 1'b0);
	endtask

	// bytes ahead of any packet mark, then a zero-length section and a plain one
	task automatic test_stray_and_zero_length();
		repeat (3) send_byte(byte_t'($urandom), 1'b0);
		send_good_packet(10, -1, 0);
		send_good_packet(12, 0, 5);
		send_good_packet(8, -1, 0);
	endtask

	// top PID value, and payload on a packet without unit start and no section open
	task automatic test_pid_extremes();
		write_pid(PID_MAX);
		send_good_packet(20, -1, 8);
		send_noise_packet(NOISE_LONE_PAYLOAD, 16);
	endtask

	// section header cut after one and after two bytes
	task automatic test_split_header();
		send_good_packet(6, -1, 4);
		send_good_packet(10, -1, 0);
		send_good_packet(7, -1, 3);
		send_good_packet(10, -1, 0);
	endtask

	// spoilt packets in the middle of a section must not disturb it
	task automatic test_rejected_packets();
		send_good_packet(9, -1, 30);
		send_noise_packet(NOISE_WRONG_PID, 20);
		send_noise_packet(NOISE_BAD_SYNC, 20);
		send_noise_packet(NOISE_BAD_CC, 20);
		send_noise_packet(NOISE_NO_PAYLOAD, 20);
		send_noise_packet(NOISE_ADAPT_FILL, 20);
		send_noise_packet(NOISE_RUNT, 2);
		while (m_active)
			send_good_packet(24, -1, 0);
	endtask

	// adaptation fields, including ones that swallow the whole packet
	task automatic test_adaptation();
		send_good_packet(30, 12, 10);
		while (m_active)
			send_good_packet(20, 0, 0);
		send_noise_packet(NOISE_ADAPT_FILL, PKT_LEN);
		send_noise_packet(NOISE_ADAPT_FILL, 12);
		send_good_packet(16, -1, 2);
	endtask

	// overlong packet with trailing bytes, then a runt
	task automatic test_packet_lengths();
		send_good_packet(PKT_LEN, -1, 200);
		repeat (8) send_byte(byte_t'($urandom), 1'b0);
		while (m_active)
			send_good_packet(40, -1, 0);
		send_noise_packet(NOISE_RUNT, 3);
		send_good_packet(14, -1, 1);
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	task automatic test_backpressure();
		write_pid(pid_t'($urandom));
		in_idle_pct   = 0;
		stall_request = LONG_STALL;
		send_good_packet(60, -1, 40);
		while (m_active)
			send_good_packet(PKT_LEN, -1, 0);
		in_idle_pct = IDLE_PCT;
	endtask

	// length field with every low bit set, spanning two packets
	task automatic test_longest_section();
		send_good_packet(PKT_LEN, -1, 255);
		while (m_active)
			send_good_packet(80, -1, 0);
	endtask

	// mostly well-formed traffic with noise, over several PID settings
	task automatic test_random_traffic();
		pid_t        pids[4];
		int          phase;
		int          start;
		int          pick;
		int          len;
		int          alen;
		int          sec_len;
		noise_kind_e kind;
		pids = '{pid_t'($urandom), '0, pid_t'($urandom), PID_MAX};
		for (phase = 0; phase < 4; phase++) begin
			write_pid(pids[phase]);
			// second phase runs flat out on both sides
			in_idle_pct  = (phase == 1) ? 0 : IDLE_PCT;
			out_idle_pct = in_idle_pct;
			start = bytes_sent;
			while (bytes_sent - start < RANDOM_BYTES / 4) begin
				pick    = $urandom_range(0, 99);
				len     = $urandom_range(0, 99);
				len     = (len < 50) ? $urandom_range(6, 40) :
					(len < 85) ? $urandom_range(41, 187) : PKT_LEN;
				alen    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : -1;
				sec_len = ($urandom_range(0, 5) == 0) ? $urandom_range(41, 300) :
					$urandom_range(0, 40);
				if (pick < 72) begin
					send_good_packet(len, alen, sec_len);
				end else if (pick < 80) begin
					send_good_packet(PKT_LEN, -1, sec_len);
					repeat ($urandom_range(1, 12)) send_byte(byte_t'($urandom), 1'b0);
				end else begin
					kind = noise_kind_e'($urandom_range(0, 6));
					if (kind == NOISE_LONE_PAYLOAD && m_active)
						kind = NOISE_WRONG_PID;
					send_noise_packet(kind, (kind == NOISE_RUNT) ?
						$urandom_range(1, 3) : $urandom_range(5, 60));
				end
			end
		end
		in_idle_pct  = IDLE_PCT;
		out_idle_pct = IDLE_PCT;
	endtask

	// receiver side: random stalls plus the requested long hold-off
	initial begin : out_ready_drive
		int stall_left;
		stall_left   = 0;
		sec_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request != 0) begin
				stall_left    = stall_request;
				stall_request = 0;
			end
			if (stall_left != 0) begin
				stall_left--;
				sec_ch.ready <= 1'b0;
			end else begin
				sec_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
			end
		end
	end

	// compare every section byte taken against the oldest prediction
	always @(posedge clk) begin : section_check
		sec_byte_t want;
		if (arst_n && sec_ch.valid && sec_ch.ready) begin
			if (section_due.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: section item expected none, got byte %02h last %0b",
						$time, sec_ch.section_byte, sec_ch.section_last);
			end else begin
				want = section_due.pop_front();
				if (sec_ch.section_byte !== want.data) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("%0t: section_byte expected %02h, got %02h",
							$time, want.data, sec_ch.section_byte);
				end
				if (sec_ch.section_last !== want.last) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("%0t: section_last expected %0b, got %0b",
							$time, want.last, sec_ch.section_last);
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d section bytes outstanding",
			cycle_count, section_due.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		ts_ch.valid        = 1'b0;
		ts_ch.ts_byte      = '0;
		ts_ch.packet_first = 1'b0;

		// mirror starts from the reset state
		m_pid       = '0;
		m_index     = '0;
		m_keep      = 1'b0;
		m_pid_hi    = '0;
		m_pusi      = 1'b0;
		m_flags     = '0;
		m_begin     = HDR_LEN;
		m_cc        = '0;
		m_cc_valid  = 1'b0;
		m_active    = 1'b0;
		m_hstep     = '0;
		m_len_hi    = '0;
		m_remaining = '0;
		m_dropped   = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_stray_and_zero_length();
		test_pid_extremes();
		test_split_header();
		test_rejected_packets();
		test_adaptation();
		test_packet_lengths();
		test_backpressure();
		test_longest_section();
		test_random_traffic();

		// drain, then allow for late stray output
		release_input();
		while (section_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
